// ----- hdl/lazy_init_block_free_list_macros.svh -----
// ----------------------------------------------------------------------------
// lazy_init_block_free_list_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef LAZY_INIT_BLOCK_FREE_LIST_MACROS_SVH
`define LAZY_INIT_BLOCK_FREE_LIST_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define LBFL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbfl assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define LBFL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbfl assertion failed");

`endif

// ----- hdl/lbfl_pkg.sv -----
// ----------------------------------------------------------------------------
// lbfl_pkg
// Types and constants for the lazily initialized block free list.
// ----------------------------------------------------------------------------
package lbfl_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = 9;
  localparam int BS_W       = 16;
  localparam int OFF_W      = 32;
  localparam int LIMIT_W    = CNT_W + BS_W;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b1;

  localparam logic [CNT_W-1:0] RST_BLOCK_COUNT = 9'd256;
  localparam logic [BS_W-1:0]  RST_BLOCK_SIZE  = 16'd64;

  typedef enum logic {
    ST_IDLE,
    ST_LINK
  } state_t;

  typedef struct packed {
    logic load;   // transaction accepted this cycle
    logic link;   // follow the head's link from the store read
  } ctrl_cmd_t;

  typedef struct packed {
    logic link_req;  // incoming alloc grants and the list stays non-empty
  } dp_status_t;

  // Number of blocks actually managed.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] bc);
    logic [CNT_W-1:0] cap;
    cap = CNT_W'(MAX_BLOCKS);
    return (bc > cap) ? cap : bc;
  endfunction

endpackage

// ----- hdl/lbfl_ctrl.sv -----
// ----------------------------------------------------------------------------
// lbfl_ctrl
// Sequencer: handshakes, result valid and the link follow-up cycle.
// ----------------------------------------------------------------------------
module lbfl_ctrl import lbfl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && status.link_req) begin
          state_next = ST_LINK;
        end
      end
      ST_LINK: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE) || (out_valid && out_stall);
    accept   = in_valid && !in_stall;
    cmd.load = accept;
    cmd.link = (state == ST_LINK);
    if (accept) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

endmodule

// ----- hdl/lbfl_dp.sv -----
// ----------------------------------------------------------------------------
// lbfl_dp
// Datapath: config registers, link store, list head and counters, results.
// ----------------------------------------------------------------------------
module lbfl_dp import lbfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output dp_status_t           status,
  input  logic [OP_W-1:0]      op,
  input  logic [IDX_W-1:0]     block_index,
  input  logic [OFF_W-1:0]     byte_offset,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BS_W-1:0]      cfg_data,
  output logic                 granted,
  output logic [IDX_W-1:0]     alloc_index,
  output logic                 in_range
);

  logic [CNT_W-1:0]   link_store [MAX_BLOCKS];
  logic [CNT_W-1:0]   rdata;

  logic [CNT_W-1:0]   block_count;
  logic [BS_W-1:0]    block_size;
  logic [CNT_W-1:0]   n;
  logic [LIMIT_W-1:0] limit;

  logic [IDX_W-1:0]   head;
  logic               head_valid;
  logic [CNT_W-1:0]   free_count;
  logic [CNT_W-1:0]   touched;
  logic               byp_hit;
  logic [CNT_W-1:0]   byp_val;

  logic               is_alloc;
  logic               is_free;
  logic               is_check;
  logic               touch;
  logic               grant;
  logic               free_ok;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [CNT_W-1:0]   wr_data;
  logic [CNT_W-1:0]   touched_inc;
  logic [CNT_W-1:0]   nx;
  logic [CNT_W-1:0]   bc_new;
  logic [BS_W-1:0]    bs_new;
  logic [CNT_W-1:0]   n_new;

  always_comb begin
    is_alloc    = (op == OP_ALLOC);
    is_free     = (op == OP_FREE);
    is_check    = (op == OP_CHECK);
    touch       = (touched < n);
    grant       = (free_count != '0) && head_valid && ({1'b0, head} < n);
    free_ok     = ({1'b0, block_index} < n);
    touched_inc = touched + CNT_W'(1);
    status.link_req = is_alloc && grant && (free_count != CNT_W'(1));

    wr_en   = cmd.load && ((is_alloc && touch) || (is_free && free_ok));
    wr_addr = is_alloc ? touched[IDX_W-1:0] : block_index;
    if (is_alloc) begin
      wr_data = touched_inc;
    end else begin
      wr_data = head_valid ? {1'b0, head} : n;
    end

    // The store write of this alloc may target the head itself
    nx = byp_hit ? byp_val : rdata;

    bc_new = (cfg_index == CFG_BLOCK_COUNT) ? cfg_data[CNT_W-1:0] : block_count;
    bs_new = (cfg_index == CFG_BLOCK_SIZE) ? cfg_data : block_size;
    n_new  = eff_count(bc_new);
  end

  // Link store: no reset, entries are valid once written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_store[wr_addr] <= wr_data;
    end
    rdata <= link_store[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= RST_BLOCK_COUNT;
      block_size  <= RST_BLOCK_SIZE;
      n           <= eff_count(RST_BLOCK_COUNT);
      limit       <= LIMIT_W'(eff_count(RST_BLOCK_COUNT)) * LIMIT_W'(RST_BLOCK_SIZE);
      head        <= '0;
      head_valid  <= (eff_count(RST_BLOCK_COUNT) != '0);
      free_count  <= eff_count(RST_BLOCK_COUNT);
      touched     <= '0;
    end else if (cfg_we) begin
      // Any config write restarts the list
      block_count <= bc_new;
      block_size  <= bs_new;
      n           <= n_new;
      limit       <= LIMIT_W'(n_new) * LIMIT_W'(bs_new);
      head        <= '0;
      head_valid  <= (n_new != '0);
      free_count  <= n_new;
      touched     <= '0;
    end else if (cmd.load) begin
      if (is_alloc) begin
        if (touch) begin
          touched <= touched_inc;
        end
        if (grant) begin
          free_count <= free_count - CNT_W'(1);
          if (free_count == CNT_W'(1)) begin
            head_valid <= 1'b0;
          end
        end
      end else if (is_free && free_ok) begin
        head       <= block_index;
        head_valid <= 1'b1;
        if (free_count < n) begin
          free_count <= free_count + CNT_W'(1);
        end
      end
    end else if (cmd.link) begin
      if (nx < n) begin
        head <= nx[IDX_W-1:0];
      end else begin
        head_valid <= 1'b0;
      end
    end
  end

  // Bypass and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byp_hit     <= is_alloc && touch && (touched[IDX_W-1:0] == head);
      byp_val     <= touched_inc;
      granted     <= is_alloc && grant;
      alloc_index <= (is_alloc && grant) ? head : '0;
      in_range    <= is_check && (OFF_W'(limit) > byte_offset);
    end
  end

endmodule

// ----- hdl/lazy_init_block_free_list.sv -----
// ----------------------------------------------------------------------------
// lazy_init_block_free_list
// Fixed-block allocator whose free list is a link store filled on demand.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries op, block_index and
//   byte_offset: op 0 allocates, op 1 frees block_index, op 2 checks
//   byte_offset against min(block_count, 256) * block_size.
//   Output channel (out_valid / out_stall) returns granted, alloc_index and
//   in_range, one result per transaction, in order.
//   Latency: the result is valid the cycle after the input is accepted.
//   Throughput: one transaction per cycle unless the output stalls, except an
//   allocate that grants a block while others stay free: in_stall holds off
//   the next input during ST_LINK, since the head's link comes from a
//   registered read of the link store and the head is updated the next cycle.
//   A pending result may be taken in the same cycle a new input is accepted.
//   While the receiver stalls, the result is held and in_stall goes high.
//   Config writes (cfg_we, cfg_index, cfg_data) restart the list; issue them
//   only while idle.
//   Reset: block_count 256, block_size 64, full list, no pending result. The
//   link store needs no clearing; entries are written before they are read.
// ----------------------------------------------------------------------------
module lazy_init_block_free_list import lbfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      op,
  input  logic [IDX_W-1:0]     block_index,
  input  logic [OFF_W-1:0]     byte_offset,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 granted,
  output logic [IDX_W-1:0]     alloc_index,
  output logic                 in_range,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BS_W-1:0]      cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lbfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lbfl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .op          (op),
    .block_index (block_index),
    .byte_offset (byte_offset),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .granted     (granted),
    .alloc_index (alloc_index),
    .in_range    (in_range)
  );

endmodule

// ----- hdl/lbfl_checker.sv -----
// ----------------------------------------------------------------------------
// lbfl_checker
// Port-level checks on the free list allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "lazy_init_block_free_list_macros.svh"

module lbfl_checker import lbfl_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             granted,
  input logic [IDX_W-1:0] alloc_index,
  input logic             in_range
);

  // A stalled result stays pending
  `LBFL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

  // Every accepted transaction yields a result the next cycle
  `LBFL_ASSERT_NXT(a_accept_result, in_valid && !in_stall, out_valid)

  // A grant never comes with a range hit
  `LBFL_ASSERT_IMP(a_grant_excl, out_valid && granted, !in_range)

  // A refused or non-alloc result reports block zero
  `LBFL_ASSERT_IMP(a_idx_zero, out_valid && !granted, alloc_index == '0)

endmodule

bind lazy_init_block_free_list lbfl_checker u_lbfl_checker (.*);
